@@ sv/thbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbe_pkg
// Shared widths, codes and types of the triangle hierarchical basis evaluator.
// ----------------------------------------------------------------------------
package thbe_pkg;

   // fixed field widths
   localparam int IN_W      = 16;
   localparam int OUT_W     = 17;
   localparam int MODE_W    = 4;
   localparam int ORDER_W   = 2;
   localparam int NUM_MODES = 10;

   // default number of fraction bits of the coordinates and results
   localparam int FRAC_BITS_DEF = 14;

   // saturation limits of a result field
   localparam int OUT_MAX_VAL = 2 ** (OUT_W - 1) - 1;
   localparam int OUT_MIN_VAL = -(2 ** (OUT_W - 1));

   // polynomial order codes
   localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_QUAD   = 2'd2;
   localparam logic [ORDER_W-1:0] ORDER_CUBIC  = 2'd3;
   localparam logic [ORDER_W-1:0] ORDER_RESET  = ORDER_CUBIC;

   // final mode number for each order, bubble mode, index step
   localparam logic [MODE_W-1:0] LAST_MODE_LINEAR = 4'd2;
   localparam logic [MODE_W-1:0] LAST_MODE_QUAD   = 4'd5;
   localparam logic [MODE_W-1:0] LAST_MODE_CUBIC  = 4'd9;
   localparam logic [MODE_W-1:0] MODE_ONE         = 4'd1;
   localparam int                BUBBLE_MODE      = 9;

   // first level products (rounded), in slot order
   localparam int NUM_PROD = 9;
   localparam int P01  = 0;   // l0 * l1
   localparam int P12  = 1;   // l1 * l2
   localparam int P20  = 2;   // l2 * l0
   localparam int PGG  = 3;   // g * g
   localparam int PKK  = 4;   // k * k
   localparam int PL1G = 5;   // l1 * g
   localparam int PL2H = 6;   // l2 * h
   localparam int PL1H = 7;   // l1 * h
   localparam int PL2K = 8;   // l2 * k

   // second level products
   localparam int NUM_SQ = 4;
   localparam int Q01G   = 0; // p01 * g
   localparam int Q12H   = 1; // p12 * h
   localparam int Q20K   = 2; // p20 * k
   localparam int Q01L2  = 3; // p01 * l2

   // one finished mode: value and both partial derivatives
   typedef struct packed {
      logic signed [OUT_W-1:0] value;
      logic signed [OUT_W-1:0] d0;
      logic signed [OUT_W-1:0] d1;
   } result_type;

   // width of a barycentric coordinate held with frac+1 fraction bits
   function automatic int bary_width(input int frac);
      return (frac + 2 > IN_W + 2) ? frac + 2 : IN_W + 2;
   endfunction

endpackage

@@ sv/thbe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbe_front
// Barycentric coordinates, first level products and their rounding, in three
// pipeline stages.
// ----------------------------------------------------------------------------
module thbe_front #(
   parameter int  FRAC_BITS = thbe_pkg::FRAC_BITS_DEF,
   localparam int LW        = thbe_pkg::bary_width(FRAC_BITS),
   localparam int DW        = LW + 1,
   localparam int MW        = 2 * DW,
   localparam int PRW       = MW - FRAC_BITS - 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [thbe_pkg::IN_W-1:0] xi0,
   input  logic signed [thbe_pkg::IN_W-1:0] xi1,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [LW-1:0]           l0,
   output logic signed [LW-1:0]           l1,
   output logic signed [LW-1:0]           l2,
   output logic signed [DW-1:0]           g,
   output logic signed [DW-1:0]           h,
   output logic signed [DW-1:0]           k,
   output logic signed [PRW-1:0]          prod [thbe_pkg::NUM_PROD]
);

   // one half in the frac+1 format, and the rounding offset of a product
   localparam logic signed [LW-1:0] ONE  = LW'(1) << FRAC_BITS;
   localparam logic signed [MW-1:0] HALF = MW'(1) << FRAC_BITS;

   logic ready_a, ready_b, ready_c;
   logic vld_a_ff, vld_b_ff, vld_c_ff;

   logic signed [LW-1:0] l0_in, l1_in, l2_in;
   logic signed [DW-1:0] g_in, h_in, k_in;
   logic signed [LW-1:0] l0_a_ff, l1_a_ff, l2_a_ff;
   logic signed [DW-1:0] g_a_ff, h_a_ff, k_a_ff;

   logic signed [DW-1:0] opa [thbe_pkg::NUM_PROD];
   logic signed [DW-1:0] opb [thbe_pkg::NUM_PROD];
   logic signed [MW-1:0] mb_in [thbe_pkg::NUM_PROD];
   logic signed [MW-1:0] mb_b_ff [thbe_pkg::NUM_PROD];
   logic signed [LW-1:0] l0_b_ff, l1_b_ff, l2_b_ff;
   logic signed [DW-1:0] g_b_ff, h_b_ff, k_b_ff;

   logic signed [MW-1:0]  rsum [thbe_pkg::NUM_PROD];
   logic signed [PRW-1:0] prod_in [thbe_pkg::NUM_PROD];
   logic signed [PRW-1:0] prod_c_ff [thbe_pkg::NUM_PROD];
   logic signed [LW-1:0]  l0_c_ff, l1_c_ff, l2_c_ff;
   logic signed [DW-1:0]  g_c_ff, h_c_ff, k_c_ff;

   // stage advance: a slot loads when empty or when its successor moves
   assign ready_c  = !vld_c_ff || out_ready;
   assign ready_b  = !vld_b_ff || ready_c;
   assign ready_a  = !vld_a_ff || ready_b;
   assign in_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else begin
         if (ready_a) vld_a_ff <= in_valid;
         if (ready_b) vld_b_ff <= vld_a_ff;
         if (ready_c) vld_c_ff <= vld_b_ff;
      end
   end

   // stage a: barycentric coordinates and their differences
   assign l0_in = -(LW'(xi0) + LW'(xi1));
   assign l1_in = ONE + LW'(xi0);
   assign l2_in = ONE + LW'(xi1);
   assign g_in  = DW'(l1_in) - DW'(l0_in);
   assign h_in  = DW'(l2_in) - DW'(l1_in);
   assign k_in  = DW'(l0_in) - DW'(l2_in);

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         l0_a_ff <= l0_in;
         l1_a_ff <= l1_in;
         l2_a_ff <= l2_in;
         g_a_ff  <= g_in;
         h_a_ff  <= h_in;
         k_a_ff  <= k_in;
      end
   end

   // stage b: nine full width products
   always_comb begin
      opa[thbe_pkg::P01]  = DW'(l0_a_ff);  opb[thbe_pkg::P01]  = DW'(l1_a_ff);
      opa[thbe_pkg::P12]  = DW'(l1_a_ff);  opb[thbe_pkg::P12]  = DW'(l2_a_ff);
      opa[thbe_pkg::P20]  = DW'(l2_a_ff);  opb[thbe_pkg::P20]  = DW'(l0_a_ff);
      opa[thbe_pkg::PGG]  = g_a_ff;        opb[thbe_pkg::PGG]  = g_a_ff;
      opa[thbe_pkg::PKK]  = k_a_ff;        opb[thbe_pkg::PKK]  = k_a_ff;
      opa[thbe_pkg::PL1G] = DW'(l1_a_ff);  opb[thbe_pkg::PL1G] = g_a_ff;
      opa[thbe_pkg::PL2H] = DW'(l2_a_ff);  opb[thbe_pkg::PL2H] = h_a_ff;
      opa[thbe_pkg::PL1H] = DW'(l1_a_ff);  opb[thbe_pkg::PL1H] = h_a_ff;
      opa[thbe_pkg::PL2K] = DW'(l2_a_ff);  opb[thbe_pkg::PL2K] = k_a_ff;
      for (int i = 0; i < thbe_pkg::NUM_PROD; i++) begin
         mb_in[i] = opa[i] * opb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b && vld_a_ff) begin
         mb_b_ff <= mb_in;
         l0_b_ff <= l0_a_ff;
         l1_b_ff <= l1_a_ff;
         l2_b_ff <= l2_a_ff;
         g_b_ff  <= g_a_ff;
         h_b_ff  <= h_a_ff;
         k_b_ff  <= k_a_ff;
      end
   end

   // stage c: round each product half up back to frac+1 fraction bits
   always_comb begin
      for (int i = 0; i < thbe_pkg::NUM_PROD; i++) begin
         rsum[i]    = mb_b_ff[i] + HALF;
         prod_in[i] = rsum[i][MW-1:FRAC_BITS+1];
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c && vld_b_ff) begin
         prod_c_ff <= prod_in;
         l0_c_ff   <= l0_b_ff;
         l1_c_ff   <= l1_b_ff;
         l2_c_ff   <= l2_b_ff;
         g_c_ff    <= g_b_ff;
         h_c_ff    <= h_b_ff;
         k_c_ff    <= k_b_ff;
      end
   end

   assign out_valid = vld_c_ff;
   assign l0        = l0_c_ff;
   assign l1        = l1_c_ff;
   assign l2        = l2_c_ff;
   assign g         = g_c_ff;
   assign h         = h_c_ff;
   assign k         = k_c_ff;
   assign prod      = prod_c_ff;

endmodule

@@ sv/thbe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbe_back
// Cubic products, assembly of all mode values and derivatives, and final
// rounding with saturation, in three pipeline stages.
// ----------------------------------------------------------------------------
module thbe_back #(
   parameter int  FRAC_BITS = thbe_pkg::FRAC_BITS_DEF,
   localparam int LW        = thbe_pkg::bary_width(FRAC_BITS),
   localparam int DW        = LW + 1,
   localparam int MW        = 2 * DW,
   localparam int PRW       = MW - FRAC_BITS - 1,
   localparam int SQW       = PRW + DW,
   localparam int QW        = SQW - FRAC_BITS - 1,
   localparam int AW        = QW + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [LW-1:0]  l0,
   input  logic signed [LW-1:0]  l1,
   input  logic signed [LW-1:0]  l2,
   input  logic signed [DW-1:0]  g,
   input  logic signed [DW-1:0]  h,
   input  logic signed [DW-1:0]  k,
   input  logic signed [PRW-1:0] prod [thbe_pkg::NUM_PROD],
   output logic                  out_valid,
   input  logic                  out_ready,
   output thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0] res
);

   localparam logic signed [SQW-1:0] HALF_SQ = SQW'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0]  ONE     = AW'(1) << FRAC_BITS;
   localparam logic signed [AW:0]    SAT_HI  = (AW+1)'(thbe_pkg::OUT_MAX_VAL);
   localparam logic signed [AW:0]    SAT_LO  = (AW+1)'(thbe_pkg::OUT_MIN_VAL);

   // round half up by one or two bits, then clamp to the result range
   function automatic logic signed [thbe_pkg::OUT_W-1:0] sat_out(
      input logic signed [AW-1:0] x,
      input logic                 wide_shift
   );
      logic signed [AW:0] t;
      logic signed [AW:0] r;
      logic signed [thbe_pkg::OUT_W-1:0] o;
      t = (AW+1)'(x) + (wide_shift ? (AW+1)'(2) : (AW+1)'(1));
      r = wide_shift ? (t >>> 2) : (t >>> 1);
      if (r > SAT_HI) begin
         o = SAT_HI[thbe_pkg::OUT_W-1:0];
      end else if (r < SAT_LO) begin
         o = SAT_LO[thbe_pkg::OUT_W-1:0];
      end else begin
         o = r[thbe_pkg::OUT_W-1:0];
      end
      return o;
   endfunction

   logic ready_d, ready_e, ready_f;
   logic vld_d_ff, vld_e_ff, vld_f_ff;

   logic signed [PRW-1:0] sqa [thbe_pkg::NUM_SQ];
   logic signed [DW-1:0]  sqb [thbe_pkg::NUM_SQ];
   logic signed [SQW-1:0] sq_in [thbe_pkg::NUM_SQ];
   logic signed [SQW-1:0] sq_d_ff [thbe_pkg::NUM_SQ];
   logic signed [PRW-1:0] prod_d_ff [thbe_pkg::NUM_PROD];
   logic signed [LW-1:0]  l0_d_ff, l1_d_ff, l2_d_ff;
   logic signed [DW-1:0]  g_d_ff, k_d_ff;

   logic signed [SQW-1:0] qsum [thbe_pkg::NUM_SQ];
   logic signed [QW-1:0]  q [thbe_pkg::NUM_SQ];
   logic signed [AW-1:0]  x_l0, x_l1, x_l2, x_g, x_k;
   logic signed [AW-1:0]  x_p01, x_p12, x_p20, x_gg, x_kk;
   logic signed [AW-1:0]  x_l1g, x_l2h, x_l1h, x_l2k;
   logic signed [AW-1:0]  x_q01g, x_q12h, x_q20k, x_q01l2;
   logic signed [AW-1:0]  pv_in [thbe_pkg::NUM_MODES];
   logic signed [AW-1:0]  dx_in [thbe_pkg::NUM_MODES];
   logic signed [AW-1:0]  dy_in [thbe_pkg::NUM_MODES];
   logic signed [AW-1:0]  pv_e_ff [thbe_pkg::NUM_MODES];
   logic signed [AW-1:0]  dx_e_ff [thbe_pkg::NUM_MODES];
   logic signed [AW-1:0]  dy_e_ff [thbe_pkg::NUM_MODES];

   thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0] res_in;
   thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0] res_f_ff;

   // stage advance
   assign ready_f  = !vld_f_ff || out_ready;
   assign ready_e  = !vld_e_ff || ready_f;
   assign ready_d  = !vld_d_ff || ready_e;
   assign in_ready = ready_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         vld_f_ff <= 1'b0;
      end else begin
         if (ready_d) vld_d_ff <= in_valid;
         if (ready_e) vld_e_ff <= vld_d_ff;
         if (ready_f) vld_f_ff <= vld_e_ff;
      end
   end

   // stage d: cubic products of the rounded pair products
   always_comb begin
      sqa[thbe_pkg::Q01G]  = prod[thbe_pkg::P01];  sqb[thbe_pkg::Q01G]  = g;
      sqa[thbe_pkg::Q12H]  = prod[thbe_pkg::P12];  sqb[thbe_pkg::Q12H]  = h;
      sqa[thbe_pkg::Q20K]  = prod[thbe_pkg::P20];  sqb[thbe_pkg::Q20K]  = k;
      sqa[thbe_pkg::Q01L2] = prod[thbe_pkg::P01];  sqb[thbe_pkg::Q01L2] = DW'(l2);
      for (int i = 0; i < thbe_pkg::NUM_SQ; i++) begin
         sq_in[i] = sqa[i] * sqb[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d && in_valid) begin
         sq_d_ff   <= sq_in;
         prod_d_ff <= prod;
         l0_d_ff   <= l0;
         l1_d_ff   <= l1;
         l2_d_ff   <= l2;
         g_d_ff    <= g;
         k_d_ff    <= k;
      end
   end

   // stage e: round cubic products, then assemble every pre-rounding output
   always_comb begin
      for (int i = 0; i < thbe_pkg::NUM_SQ; i++) begin
         qsum[i] = sq_d_ff[i] + HALF_SQ;
         q[i]    = qsum[i][SQW-1:FRAC_BITS+1];
      end
   end

   assign x_l0    = AW'(l0_d_ff);
   assign x_l1    = AW'(l1_d_ff);
   assign x_l2    = AW'(l2_d_ff);
   assign x_g     = AW'(g_d_ff);
   assign x_k     = AW'(k_d_ff);
   assign x_p01   = AW'(prod_d_ff[thbe_pkg::P01]);
   assign x_p12   = AW'(prod_d_ff[thbe_pkg::P12]);
   assign x_p20   = AW'(prod_d_ff[thbe_pkg::P20]);
   assign x_gg    = AW'(prod_d_ff[thbe_pkg::PGG]);
   assign x_kk    = AW'(prod_d_ff[thbe_pkg::PKK]);
   assign x_l1g   = AW'(prod_d_ff[thbe_pkg::PL1G]);
   assign x_l2h   = AW'(prod_d_ff[thbe_pkg::PL2H]);
   assign x_l1h   = AW'(prod_d_ff[thbe_pkg::PL1H]);
   assign x_l2k   = AW'(prod_d_ff[thbe_pkg::PL2K]);
   assign x_q01g  = AW'(q[thbe_pkg::Q01G]);
   assign x_q12h  = AW'(q[thbe_pkg::Q12H]);
   assign x_q20k  = AW'(q[thbe_pkg::Q20K]);
   assign x_q01l2 = AW'(q[thbe_pkg::Q01L2]);

   always_comb begin
      // linear modes
      pv_in[0] = x_l0;              dx_in[0] = -ONE;             dy_in[0] = -ONE;
      pv_in[1] = x_l1;              dx_in[1] = ONE;              dy_in[1] = '0;
      pv_in[2] = x_l2;              dx_in[2] = '0;               dy_in[2] = ONE;
      // quadratic edge modes
      pv_in[3] = -(x_p01 <<< 1);    dx_in[3] = x_g;              dy_in[3] = x_l1;
      pv_in[4] = -(x_p12 <<< 1);    dx_in[4] = -x_l2;            dy_in[4] = -x_l1;
      pv_in[5] = -(x_p20 <<< 1);    dx_in[5] = x_l2;             dy_in[5] = -x_k;
      // cubic edge modes
      pv_in[6] = -(x_q01g <<< 1);
      dx_in[6] = x_gg - (x_p01 <<< 1);
      dy_in[6] = x_l1g - x_p01;
      pv_in[7] = -(x_q12h <<< 1);
      dx_in[7] = x_p12 - x_l2h;
      dy_in[7] = -x_l1h - x_p12;
      pv_in[8] = -(x_q20k <<< 1);
      dx_in[8] = x_l2k + x_p20;
      dy_in[8] = (x_p20 <<< 1) - x_kk;
      // bubble mode, derivatives carry an extra half
      pv_in[9] = x_q01l2;
      dx_in[9] = x_p20 - x_p12;
      dy_in[9] = x_p01 - x_p12;
   end

   always_ff @(posedge clock) begin
      if (ready_e && vld_d_ff) begin
         pv_e_ff <= pv_in;
         dx_e_ff <= dx_in;
         dy_e_ff <= dy_in;
      end
   end

   // stage f: round to the output format and saturate
   always_comb begin
      for (int i = 0; i < thbe_pkg::NUM_MODES; i++) begin
         res_in[i].value = sat_out(pv_e_ff[i], 1'b0);
         res_in[i].d0    = sat_out(dx_e_ff[i], i == thbe_pkg::BUBBLE_MODE);
         res_in[i].d1    = sat_out(dy_e_ff[i], i == thbe_pkg::BUBBLE_MODE);
      end
   end

   always_ff @(posedge clock) begin
      if (ready_f && vld_e_ff) begin
         res_f_ff <= res_in;
      end
   end

   assign out_valid = vld_f_ff;
   assign res       = res_f_ff;

endmodule

@@ sv/thbe_serial.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbe_serial
// Holds the finished modes of one point and sends them one per cycle unless
// stalled, taking the next point as the final mode of the current one leaves.
// ----------------------------------------------------------------------------
module thbe_serial (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0]  in_res,
   input  logic [thbe_pkg::ORDER_W-1:0]                    basis_order,
   output logic                                            out_valid,
   input  logic                                            out_stall,
   output logic [thbe_pkg::MODE_W-1:0]                     out_index,
   output logic signed [thbe_pkg::OUT_W-1:0]               out_value,
   output logic signed [thbe_pkg::OUT_W-1:0]               out_d0,
   output logic signed [thbe_pkg::OUT_W-1:0]               out_d1,
   output logic                                            out_last
);

   thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0] res_ff;
   logic [thbe_pkg::MODE_W-1:0] idx_ff, idx_in;
   logic                        busy_ff, busy_in;
   logic [thbe_pkg::MODE_W-1:0] last_idx;
   logic                        is_last, fire, done, load;

   // final mode number for the configured order
   always_comb begin
      case (basis_order)
         thbe_pkg::ORDER_CUBIC: last_idx = thbe_pkg::LAST_MODE_CUBIC;
         thbe_pkg::ORDER_QUAD:  last_idx = thbe_pkg::LAST_MODE_QUAD;
         default:               last_idx = thbe_pkg::LAST_MODE_LINEAR;
      endcase
   end

   assign is_last  = (idx_ff == last_idx);
   assign fire     = busy_ff && !out_stall;
   assign done     = fire && is_last;
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   // mode counter and busy flag
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         idx_in = idx_ff + thbe_pkg::MODE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // result holding register
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= in_res;
      end
   end

   assign out_valid = busy_ff;
   assign out_index = idx_ff;
   assign out_value = res_ff[idx_ff].value;
   assign out_d0    = res_ff[idx_ff].d0;
   assign out_d1    = res_ff[idx_ff].d1;
   assign out_last  = is_last;

endmodule

@@ sv/triangle_hierarchical_basis_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_hierarchical_basis_eval
// Hierarchical edge and bubble basis on the reference triangle: for each point
// gives every mode value with both partial derivatives, up to cubic order.
// ----------------------------------------------------------------------------
//  channel  payload                                   dir  handshake
//  req      req_xi0, req_xi1                          in   req_valid / req_stall
//  rsp      rsp_mode_index, rsp_mode_value,           out  rsp_valid / rsp_stall
//           rsp_d_dxi0, rsp_d_dxi1, rsp_last
//  csr      csr_basis_order                           in   csr_valid / csr_ready
//
//  A point yields 3, 6 or 10 results for order 1, 2 or 3, one per cycle while
//  rsp_stall is low, so the single result port sets the rate of points.
//  The first result of a point passes six arithmetic stages and the result
//  holding register. Points queue in the stages while modes drain.
//  Reset clears all valid bits and sets the order to cubic; no clearing pass.
//  rsp_stall freezes the result and backs up through the stages to req_stall.
// ----------------------------------------------------------------------------
module triangle_hierarchical_basis_eval #(
   parameter int FRAC_BITS = thbe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [thbe_pkg::IN_W-1:0]    req_xi0,
   input  logic signed [thbe_pkg::IN_W-1:0]    req_xi1,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [thbe_pkg::MODE_W-1:0]         rsp_mode_index,
   output logic signed [thbe_pkg::OUT_W-1:0]   rsp_mode_value,
   output logic signed [thbe_pkg::OUT_W-1:0]   rsp_d_dxi0,
   output logic signed [thbe_pkg::OUT_W-1:0]   rsp_d_dxi1,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [thbe_pkg::ORDER_W-1:0]        csr_basis_order
);

   localparam int LW  = thbe_pkg::bary_width(FRAC_BITS);
   localparam int DW  = LW + 1;
   localparam int PRW = 2 * DW - FRAC_BITS - 1;

   logic [thbe_pkg::ORDER_W-1:0] basis_order_ff;

   logic                  front_in_ready, front_valid, back_ready;
   logic signed [LW-1:0]  f_l0, f_l1, f_l2;
   logic signed [DW-1:0]  f_g, f_h, f_k;
   logic signed [PRW-1:0] f_prod [thbe_pkg::NUM_PROD];
   logic                  back_valid, serial_ready;
   thbe_pkg::result_type [thbe_pkg::NUM_MODES-1:0] b_res;

   // order register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_order_ff <= thbe_pkg::ORDER_RESET;
      end else if (csr_valid && csr_ready) begin
         basis_order_ff <= csr_basis_order;
      end
   end

   // coordinates and first level products
   thbe_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_in_ready),
      .xi0       (req_xi0),
      .xi1       (req_xi1),
      .out_valid (front_valid),
      .out_ready (back_ready),
      .l0        (f_l0),
      .l1        (f_l1),
      .l2        (f_l2),
      .g         (f_g),
      .h         (f_h),
      .k         (f_k),
      .prod      (f_prod)
   );

   assign req_stall = !front_in_ready;

   // cubic terms, assembly and saturation
   thbe_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (back_ready),
      .l0        (f_l0),
      .l1        (f_l1),
      .l2        (f_l2),
      .g         (f_g),
      .h         (f_h),
      .k         (f_k),
      .prod      (f_prod),
      .out_valid (back_valid),
      .out_ready (serial_ready),
      .res       (b_res)
   );

   // one mode per cycle onto the result channel while rsp_stall is low
   thbe_serial u_serial (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (back_valid),
      .in_ready    (serial_ready),
      .in_res      (b_res),
      .basis_order (basis_order_ff),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_index   (rsp_mode_index),
      .out_value   (rsp_mode_value),
      .out_d0      (rsp_d_dxi0),
      .out_d1      (rsp_d_dxi1),
      .out_last    (rsp_last)
   );

`ifndef SYNTHESIS
   // the final mode of a point is always the last mode of some order
   a_last_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (rsp_mode_index == thbe_pkg::LAST_MODE_LINEAR ||
          rsp_mode_index == thbe_pkg::LAST_MODE_QUAD ||
          rsp_mode_index == thbe_pkg::LAST_MODE_CUBIC))
      else $error("last flag on a mode that ends no order");

   // modes of one point follow back to back in ascending order
   a_mode_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && rsp_mode_index == $past(rsp_mode_index) + thbe_pkg::MODE_ONE))
      else $error("mode sequence broken inside a point");

   // a new point always starts at mode zero
   a_mode_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (!rsp_valid || rsp_mode_index == '0))
      else $error("next point does not start at mode zero");
`endif

endmodule
